// File: design/ep0d_pkg.sv
// ----------------------------------------------------------------------------
// ep0d_pkg
// Shared codes and constants for the endpoint zero descriptor responder.
// ----------------------------------------------------------------------------
`default_nettype none

package ep0d_pkg;

   // Item kinds carried on the mode field.
   localparam logic [1:0] MODE_PACKET    = 2'd0;
   localparam logic [1:0] MODE_READY     = 2'd1;
   localparam logic [1:0] MODE_BUS_RESET = 2'd2;

   // Received packet lengths with a meaning.
   localparam logic [6:0] RX_LEN_STATUS = 7'd0;
   localparam logic [6:0] RX_LEN_SETUP  = 7'd8;

   // Standard request codes.
   localparam logic [7:0] REQ_ASSIGN_ADDR = 8'd5;
   localparam logic [7:0] REQ_FETCH_DESC  = 8'd6;

   // Request type field, bits 6..5 of bmRequestType.
   localparam logic [1:0] REQ_TYPE_STANDARD = 2'd0;

   // Descriptor type codes in the high byte of wValue.
   localparam logic [7:0] DTYPE_DEVICE     = 8'h01;
   localparam logic [7:0] DTYPE_CONFIG     = 8'h02;
   localparam logic [7:0] DTYPE_STRING     = 8'h03;
   localparam logic [7:0] DTYPE_QUALIFIER  = 8'h06;
   localparam logic [7:0] DTYPE_HID_REPORT = 8'h22;

   // Descriptor select codes on the result.
   localparam logic [3:0] SEL_DEVICE    = 4'd0;
   localparam logic [3:0] SEL_CONFIG    = 4'd1;
   localparam logic [3:0] SEL_STRING0   = 4'd2;
   localparam logic [3:0] SEL_QUALIFIER = 4'd6;
   localparam logic [3:0] SEL_REPORT0   = 4'd7;
   localparam logic [3:0] SEL_REPORT1   = 4'd8;
   localparam logic [3:0] SEL_NONE      = 4'd9;

   // Configuration register indexes.
   localparam logic [2:0] CSR_MAX_PACKET    = 3'd0;
   localparam logic [2:0] CSR_DEVICE_LEN    = 3'd1;
   localparam logic [2:0] CSR_CONFIG_LEN    = 3'd2;
   localparam logic [2:0] CSR_STRING_LENS   = 3'd3;
   localparam logic [2:0] CSR_QUALIFIER_LEN = 3'd4;
   localparam logic [2:0] CSR_REPORT0_LEN   = 3'd5;
   localparam logic [2:0] CSR_REPORT1_LEN   = 3'd6;

   // Configuration reset values.
   localparam logic [6:0]  RST_MAX_PACKET    = 7'd64;
   localparam logic [7:0]  RST_DEVICE_LEN    = 8'd18;
   localparam logic [7:0]  RST_QUALIFIER_LEN = 8'd10;

endpackage : ep0d_pkg

`default_nettype wire

// File: design/usb_ep0_descriptor_responder.sv
// ----------------------------------------------------------------------------
// usb_ep0_descriptor_responder
// Control endpoint zero responder for address and descriptor requests.
// ----------------------------------------------------------------------------
// Each req_ item is one endpoint event: a received packet (setup or status),
// an endpoint-ready event, or a bus reset. Every item gives exactly one rsp_
// item that says whether an IN chunk goes out now (descriptor, offset,
// length, last flag) and carries the address and status flag after the item.
// The event is decoded and the control state updated in the cycle the item
// is accepted; the result sits in the output register in the cycle after,
// and one item is taken every cycle while no result waits under rsp_stall.
// With the single output register, a new item is accepted while the held
// result is taken in the same cycle, and req_stall rises only while a result
// waits under rsp_stall. Configuration is written through csr_ and applies
// to the next item. A synchronous reset restores register defaults, closes
// the data stage, clears address and status and empties the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module usb_ep0_descriptor_responder
   import ep0d_pkg::*;
(
   input  wire  logic        clock,
   input  wire  logic        reset,

   input  wire  logic        csr_write_enable,
   input  wire  logic [2:0]  csr_index,
   input  wire  logic [31:0] csr_write_data,

   input  wire  logic        req_valid,
   output       logic        req_stall,
   input  wire  logic [1:0]  req_mode,
   input  wire  logic [6:0]  req_rx_length,
   input  wire  logic [7:0]  req_request_type,
   input  wire  logic [7:0]  req_request_code,
   input  wire  logic [15:0] req_request_value,
   input  wire  logic [15:0] req_request_index,
   input  wire  logic [15:0] req_request_length,

   output       logic        rsp_valid,
   input  wire  logic        rsp_stall,
   output       logic        rsp_send_packet,
   output       logic [3:0]  rsp_descriptor_select,
   output       logic [15:0] rsp_byte_offset,
   output       logic [6:0]  rsp_packet_length,
   output       logic        rsp_last_packet,
   output       logic [6:0]  rsp_device_address,
   output       logic        rsp_status_done
);

   // Configuration registers.
   logic [6:0]  max_packet_ff;
   logic [7:0]  device_len_ff;
   logic [15:0] config_len_ff;
   logic [31:0] string_lens_ff;
   logic [7:0]  qualifier_len_ff;
   logic [15:0] report0_len_ff;
   logic [15:0] report1_len_ff;

   // Control state.
   logic [3:0]  desc_ff,    desc_in;
   logic [15:0] remain_ff,  remain_in;
   logic [15:0] offset_ff,  offset_in;
   logic        stage_ff,   stage_in;
   logic        status_ff,  status_in;
   logic [6:0]  address_ff, address_in;

   // Output register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic        send_ff,      send_in;
   logic [3:0]  sel_ff,       sel_in;
   logic [15:0] boff_ff,      boff_in;
   logic [6:0]  plen_ff,      plen_in;
   logic        last_ff,      last_in;

   logic        req_accept;
   logic        is_setup;
   logic        is_standard;
   logic        get_desc;
   logic [7:0]  dtype;
   logic [7:0]  dsub;
   logic        sel_ok;
   logic [3:0]  sel_code;
   logic [15:0] sel_len;
   logic [15:0] sel_remain;
   logic [3:0]  cur_desc;
   logic [15:0] cur_remain;
   logic [15:0] cur_offset;
   logic        do_send;
   logic        chunk_full;
   logic [6:0]  chunk_len;
   logic        chunk_last;

   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_packet_ff    <= RST_MAX_PACKET;
         device_len_ff    <= RST_DEVICE_LEN;
         config_len_ff    <= '0;
         string_lens_ff   <= '0;
         qualifier_len_ff <= RST_QUALIFIER_LEN;
         report0_len_ff   <= '0;
         report1_len_ff   <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_MAX_PACKET:    max_packet_ff    <= csr_write_data[6:0];
            CSR_DEVICE_LEN:    device_len_ff    <= csr_write_data[7:0];
            CSR_CONFIG_LEN:    config_len_ff    <= csr_write_data[15:0];
            CSR_STRING_LENS:   string_lens_ff   <= csr_write_data;
            CSR_QUALIFIER_LEN: qualifier_len_ff <= csr_write_data[7:0];
            CSR_REPORT0_LEN:   report0_len_ff   <= csr_write_data[15:0];
            CSR_REPORT1_LEN:   report1_len_ff   <= csr_write_data[15:0];
            default: ;
         endcase
      end
   end

   assign is_setup    = (req_mode == MODE_PACKET) && (req_rx_length == RX_LEN_SETUP);
   assign is_standard = (req_request_type[6:5] == REQ_TYPE_STANDARD);
   assign get_desc    = is_setup && is_standard && (req_request_code == REQ_FETCH_DESC);
   assign dtype       = req_request_value[15:8];
   assign dsub        = req_request_value[7:0];

   // Descriptor decode from wValue and wIndex.
   always_comb begin
      sel_ok   = 1'b1;
      sel_code = SEL_NONE;
      sel_len  = '0;
      case (dtype)
         DTYPE_DEVICE: begin
            sel_code = SEL_DEVICE;
            sel_len  = {8'd0, device_len_ff};
         end
         DTYPE_CONFIG: begin
            sel_code = SEL_CONFIG;
            sel_len  = config_len_ff;
         end
         DTYPE_STRING: begin
            sel_ok   = (dsub[7:2] == 6'd0);
            sel_code = SEL_STRING0 + {2'd0, dsub[1:0]};
            case (dsub[1:0])
               2'd0:    sel_len = {8'd0, string_lens_ff[7:0]};
               2'd1:    sel_len = {8'd0, string_lens_ff[15:8]};
               2'd2:    sel_len = {8'd0, string_lens_ff[23:16]};
               default: sel_len = {8'd0, string_lens_ff[31:24]};
            endcase
         end
         DTYPE_QUALIFIER: begin
            sel_code = SEL_QUALIFIER;
            sel_len  = {8'd0, qualifier_len_ff};
         end
         DTYPE_HID_REPORT: begin
            if (req_request_index[7:0] == 8'd0) begin
               sel_code = SEL_REPORT0;
               sel_len  = report0_len_ff;
            end else begin
               sel_code = SEL_REPORT1;
               sel_len  = report1_len_ff;
            end
         end
         default: sel_ok = 1'b0;
      endcase
   end

   assign sel_remain = (sel_len < req_request_length) ? sel_len : req_request_length;

   // An unknown descriptor leaves the stale pointer and count in place.
   assign cur_desc   = (get_desc && sel_ok) ? sel_code   : desc_ff;
   assign cur_remain = (get_desc && sel_ok) ? sel_remain : remain_ff;
   assign cur_offset = (get_desc && sel_ok) ? 16'd0      : offset_ff;

   assign do_send    = get_desc || ((req_mode == MODE_READY) && stage_ff);
   assign chunk_full = cur_remain > {9'd0, max_packet_ff};
   assign chunk_len  = chunk_full ? max_packet_ff : cur_remain[6:0];
   assign chunk_last = ~chunk_full;

   always_comb begin
      desc_in    = desc_ff;
      remain_in  = remain_ff;
      offset_in  = offset_ff;
      stage_in   = stage_ff;
      status_in  = status_ff;
      address_in = address_ff;
      if (req_accept) begin
         if ((req_mode == MODE_PACKET) && (req_rx_length == RX_LEN_STATUS)) begin
            status_in = 1'b1;
         end
         if (is_setup) begin
            status_in = 1'b0;
            stage_in  = 1'b1;
            if (is_standard && (req_request_code == REQ_ASSIGN_ADDR)) begin
               address_in = req_request_value[6:0];
            end
         end
         if (req_mode == MODE_BUS_RESET) begin
            address_in = '0;
         end
         if (do_send) begin
            desc_in   = cur_desc;
            remain_in = chunk_full ? (cur_remain - {9'd0, max_packet_ff}) : 16'd0;
            offset_in = cur_offset + {9'd0, chunk_len};
            if (chunk_last) begin
               stage_in = 1'b0;
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      send_in      = send_ff;
      sel_in       = sel_ff;
      boff_in      = boff_ff;
      plen_in      = plen_ff;
      last_in      = last_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
         send_in      = do_send;
         sel_in       = do_send ? cur_desc   : SEL_NONE;
         boff_in      = do_send ? cur_offset : 16'd0;
         plen_in      = do_send ? chunk_len  : 7'd0;
         last_in      = do_send & chunk_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         desc_ff      <= SEL_NONE;
         remain_ff    <= '0;
         offset_ff    <= '0;
         stage_ff     <= 1'b0;
         status_ff    <= 1'b0;
         address_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         desc_ff      <= desc_in;
         remain_ff    <= remain_in;
         offset_ff    <= offset_in;
         stage_ff     <= stage_in;
         status_ff    <= status_in;
         address_ff   <= address_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      send_ff <= send_in;
      sel_ff  <= sel_in;
      boff_ff <= boff_in;
      plen_ff <= plen_in;
      last_ff <= last_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_send_packet       = send_ff;
   assign rsp_descriptor_select = sel_ff;
   assign rsp_byte_offset       = boff_ff;
   assign rsp_packet_length     = plen_ff;
   assign rsp_last_packet       = last_ff;
   assign rsp_device_address    = address_ff;
   assign rsp_status_done       = status_ff;

   // The final chunk of a transfer closes the data stage.
   a_last_closes_stage: assert property (@(posedge clock) disable iff (reset)
      (req_accept && do_send && chunk_last) |=> !stage_ff)
      else $error("data stage still open after final chunk");

   // A bus reset item reports a cleared address.
   a_bus_reset_clears_address: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_mode == MODE_BUS_RESET))
         |=> (rsp_valid && (rsp_device_address == 7'd0)))
      else $error("address not cleared by bus reset");

   // A chunk that is not final is always a full packet.
   a_short_chunk_is_last: assert property (@(posedge clock) disable iff (reset)
      (req_accept && do_send && !chunk_last)
         |=> (rsp_send_packet && (rsp_packet_length == $past(max_packet_ff))))
      else $error("non-final chunk shorter than max packet");

endmodule : usb_ep0_descriptor_responder

`default_nettype wire

// File: tb/sv/tb_usb_ep0_descriptor_responder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_usb_ep0_descriptor_responder
// Self-checking testbench for the endpoint zero descriptor responder. Named
// tests drive setup, ready, status and bus reset items while a behavioral
// copy of the control state predicts every response. A checker compares each
// response field by field in order, with random idling on both channels.
// ----------------------------------------------------------------------------

module tb_usb_ep0_descriptor_responder;
   import ep0d_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int PHASE_ITEMS    = 180;
   localparam int READY_CAP      = 40;

   typedef struct packed {
      logic [1:0]  mode;
      logic [6:0]  rx_length;
      logic [7:0]  rtype;
      logic [7:0]  rcode;
      logic [15:0] value;
      logic [15:0] index;
      logic [15:0] length;
   } ep0_event_type;

   typedef struct packed {
      logic        send;
      logic [3:0]  select;
      logic [15:0] offset;
      logic [6:0]  length;
      logic        last;
      logic [6:0]  address;
      logic        status;
   } ep0_response_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_write_data = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_mode = '0;
   logic [6:0]  req_rx_length = '0;
   logic [7:0]  req_request_type = '0;
   logic [7:0]  req_request_code = '0;
   logic [15:0] req_request_value = '0;
   logic [15:0] req_request_index = '0;
   logic [15:0] req_request_length = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_send_packet;
   logic [3:0]  rsp_descriptor_select;
   logic [15:0] rsp_byte_offset;
   logic [6:0]  rsp_packet_length;
   logic        rsp_last_packet;
   logic [6:0]  rsp_device_address;
   logic        rsp_status_done;

   // Mirror of the configuration registers.
   logic [6:0]  cfg_max_packet;
   logic [7:0]  cfg_device_len;
   logic [15:0] cfg_config_len;
   logic [31:0] cfg_string_lens;
   logic [7:0]  cfg_qualifier_len;
   logic [15:0] cfg_report0_len;
   logic [15:0] cfg_report1_len;

   // Predicted control state.
   logic [3:0]  ctl_desc;
   logic [15:0] ctl_remaining;
   logic [15:0] ctl_offset;
   logic        ctl_in_data;
   logic        ctl_status;
   logic [6:0]  ctl_address;

   ep0_response_type pending_responses[$];
   int error_count = 0;
   int sent_items = 0;
   int checked_count = 0;
   int quiet_cycles = 0;
   int stall_left = 0;
   bit idle_on = 1'b0;

   usb_ep0_descriptor_responder dut (
      .clock                 (clock),
      .reset                 (reset),
      .csr_write_enable      (csr_write_enable),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_mode              (req_mode),
      .req_rx_length         (req_rx_length),
      .req_request_type      (req_request_type),
      .req_request_code      (req_request_code),
      .req_request_value     (req_request_value),
      .req_request_index     (req_request_index),
      .req_request_length    (req_request_length),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_send_packet       (rsp_send_packet),
      .rsp_descriptor_select (rsp_descriptor_select),
      .rsp_byte_offset       (rsp_byte_offset),
      .rsp_packet_length     (rsp_packet_length),
      .rsp_last_packet       (rsp_last_packet),
      .rsp_device_address    (rsp_device_address),
      .rsp_status_done       (rsp_status_done)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic reset_model();
      cfg_max_packet    = RST_MAX_PACKET;
      cfg_device_len    = RST_DEVICE_LEN;
      cfg_config_len    = '0;
      cfg_string_lens   = '0;
      cfg_qualifier_len = RST_QUALIFIER_LEN;
      cfg_report0_len   = '0;
      cfg_report1_len   = '0;
      ctl_desc          = SEL_NONE;
      ctl_remaining     = '0;
      ctl_offset        = '0;
      ctl_in_data       = 1'b0;
      ctl_status        = 1'b0;
      ctl_address       = '0;
   endtask

   // Emits the next chunk of the open transfer and advances the offset.
   function automatic ep0_response_type take_chunk(ep0_response_type r);
      logic [6:0] len;
      if (ctl_remaining > {9'd0, cfg_max_packet}) begin
         len = cfg_max_packet;
         ctl_remaining = ctl_remaining - {9'd0, len};
         r.last = 1'b0;
      end else begin
         len = ctl_remaining[6:0];
         ctl_remaining = '0;
         ctl_in_data = 1'b0;
         r.last = 1'b1;
      end
      r.send = 1'b1;
      r.select = ctl_desc;
      r.offset = ctl_offset;
      r.length = len;
      ctl_offset = ctl_offset + {9'd0, len};
      return r;
   endfunction

   function automatic ep0_response_type ep0_respond(ep0_event_type e);
      ep0_response_type r;
      logic [7:0]  dtype;
      logic [7:0]  sub;
      logic [15:0] dlen;
      logic [3:0]  sel;
      bit          known;
      r = '0;
      r.select = SEL_NONE;
      dtype = e.value[15:8];
      sub = e.value[7:0];
      dlen = '0;
      sel = SEL_NONE;
      known = 1'b1;
      case (e.mode)
         MODE_PACKET: begin
            if (e.rx_length == RX_LEN_STATUS) begin
               ctl_status = 1'b1;
            end else if (e.rx_length == RX_LEN_SETUP) begin
               // Every setup opens the data stage, whatever it asks for.
               ctl_status = 1'b0;
               ctl_in_data = 1'b1;
               if (e.rtype[6:5] == REQ_TYPE_STANDARD) begin
                  if (e.rcode == REQ_ASSIGN_ADDR) begin
                     ctl_address = e.value[6:0];
                  end else if (e.rcode == REQ_FETCH_DESC) begin
                     if (dtype == DTYPE_DEVICE) begin
                        sel = SEL_DEVICE;
                        dlen = {8'd0, cfg_device_len};
                     end else if (dtype == DTYPE_CONFIG) begin
                        sel = SEL_CONFIG;
                        dlen = cfg_config_len;
                     end else if (dtype == DTYPE_STRING && sub < 8'd4) begin
                        sel = SEL_STRING0 + sub[3:0];
                        dlen = {8'd0, cfg_string_lens[{sub[1:0], 3'b000} +: 8]};
                     end else if (dtype == DTYPE_QUALIFIER) begin
                        sel = SEL_QUALIFIER;
                        dlen = {8'd0, cfg_qualifier_len};
                     end else if (dtype == DTYPE_HID_REPORT) begin
                        sel = (e.index[7:0] == 8'd0) ? SEL_REPORT0 : SEL_REPORT1;
                        dlen = (e.index[7:0] == 8'd0) ? cfg_report0_len : cfg_report1_len;
                     end else begin
                        known = 1'b0;
                     end
                     // An unknown descriptor leaves the old transfer state in place.
                     if (known) begin
                        ctl_desc = sel;
                        ctl_remaining = (dlen < e.length) ? dlen : e.length;
                        ctl_offset = '0;
                     end
                     r = take_chunk(r);
                  end
               end
            end
         end
         MODE_READY: begin
            if (ctl_in_data) r = take_chunk(r);
         end
         MODE_BUS_RESET: begin
            ctl_address = '0;
         end
         default: ;
      endcase
      r.address = ctl_address;
      r.status = ctl_status;
      return r;
   endfunction

   function automatic ep0_event_type setup_event(logic [7:0] rtype, logic [7:0] rcode,
                                                 logic [15:0] value, logic [15:0] index,
                                                 logic [15:0] length);
      ep0_event_type e;
      e.mode = MODE_PACKET;
      e.rx_length = RX_LEN_SETUP;
      e.rtype = rtype;
      e.rcode = rcode;
      e.value = value;
      e.index = index;
      e.length = length;
      return e;
   endfunction

   function automatic ep0_event_type plain_event(logic [1:0] mode, logic [6:0] rx_length);
      ep0_event_type e;
      e = '0;
      e.mode = mode;
      e.rx_length = rx_length;
      return e;
   endfunction

   task automatic report_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      error_count++;
   endtask

   task automatic compare_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want)
         report_mismatch($sformatf("response %0d: %s is %0h, expected %0h",
                                   checked_count, name, got, want));
   endtask

   task automatic hold_sender(int cycles);
      @(negedge clock);
      req_valid = 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic send_event(ep0_event_type e);
      if (idle_on && $urandom_range(0, 5) == 0) hold_sender($urandom_range(1, 13));
      @(negedge clock);
      req_valid          = 1'b1;
      req_mode           = e.mode;
      req_rx_length      = e.rx_length;
      req_request_type   = e.rtype;
      req_request_code   = e.rcode;
      req_request_value  = e.value;
      req_request_index  = e.index;
      req_request_length = e.length;
      do @(posedge clock); while (req_stall !== 1'b0);
      pending_responses.push_back(ep0_respond(e));
      sent_items++;
   endtask

   task automatic drain_responses();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_register(logic [2:0] idx, logic [31:0] data);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index = idx;
      csr_write_data = data;
      @(posedge clock);
      case (idx)
         CSR_MAX_PACKET:    cfg_max_packet = data[6:0];
         CSR_DEVICE_LEN:    cfg_device_len = data[7:0];
         CSR_CONFIG_LEN:    cfg_config_len = data[15:0];
         CSR_STRING_LENS:   cfg_string_lens = data;
         CSR_QUALIFIER_LEN: cfg_qualifier_len = data[7:0];
         CSR_REPORT0_LEN:   cfg_report0_len = data[15:0];
         CSR_REPORT1_LEN:   cfg_report1_len = data[15:0];
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   // Writes every register; unused upper data bits carry random junk.
   task automatic load_config(logic [6:0] mp, logic [7:0] dev, logic [15:0] cfg,
                              logic [31:0] str, logic [7:0] qual, logic [15:0] rep0,
                              logic [15:0] rep1);
      logic [31:0] junk;
      junk = $urandom;
      write_register(CSR_MAX_PACKET, {junk[31:7], mp});
      junk = $urandom;
      write_register(CSR_DEVICE_LEN, {junk[31:8], dev});
      junk = $urandom;
      write_register(CSR_CONFIG_LEN, {junk[31:16], cfg});
      write_register(CSR_STRING_LENS, str);
      junk = $urandom;
      write_register(CSR_QUALIFIER_LEN, {junk[31:8], qual});
      junk = $urandom;
      write_register(CSR_REPORT0_LEN, {junk[31:16], rep0});
      junk = $urandom;
      write_register(CSR_REPORT1_LEN, {junk[31:16], rep1});
   endtask

   task automatic test_reset_defaults();
      send_event(plain_event(MODE_READY, 7'd0));
      send_event(setup_event(8'h80, REQ_FETCH_DESC, {DTYPE_DEVICE, 8'h00}, 16'h0000,
                             16'hFFFF));
      send_event(setup_event(8'h80, REQ_FETCH_DESC, {DTYPE_QUALIFIER, 8'h00}, 16'h0000,
                             16'hFFFF));
      send_event(setup_event(8'h80, REQ_FETCH_DESC, {DTYPE_CONFIG, 8'h00}, 16'h0000,
                             16'h0040));
      send_event(plain_event(MODE_READY, 7'd0));
   endtask

   task automatic test_address_and_status();
      ep0_event_type e;
      send_event(setup_event(8'h00, REQ_ASSIGN_ADDR, 16'hFFFF, 16'h0000, 16'h0000));
      // A request of reserved type must not touch the address.
      send_event(setup_event(8'hE0, REQ_ASSIGN_ADDR, 16'h0055, 16'hFFFF, 16'hFFFF));
      send_event(plain_event(MODE_READY, 7'd0));
      send_event(plain_event(MODE_PACKET, RX_LEN_STATUS));
      e = '1;
      e.mode = MODE_PACKET;
      send_event(e);
      e = '1;
      send_event(e);
      send_event(plain_event(MODE_BUS_RESET, 7'd0));
      send_event(setup_event(8'h00, 8'hFF, 16'h0000, 16'h0000, 16'h0000));
   endtask

   task automatic test_descriptor_select();
      drain_responses();
      write_register(CSR_MAX_PACKET, 32'd8);
      write_register(CSR_CONFIG_LEN, 32'd20);
      write_register(CSR_STRING_LENS, 32'hFF1E0C04);
      write_register(CSR_REPORT0_LEN, 32'd9);
      write_register(CSR_REPORT1_LEN, 32'd300);
      send_event(setup_event(8'h80, REQ_FETCH_DESC, {DTYPE_CONFIG, 8'h00}, 16'h0000,
                             16'hFFFF));
      send_event(plain_event(MODE_READY, 7'd0));
      send_event(plain_event(MODE_READY, 7'd0));
      send_event(setup_event(8'h80, REQ_FETCH_DESC, {DTYPE_STRING, 8'h03}, 16'h0409,
                             16'd5));
      // String index past the last one: the old descriptor and offset stay.
      send_event(setup_event(8'h80, REQ_FETCH_DESC, {DTYPE_STRING, 8'h04}, 16'h0409,
                             16'hFFFF));
      send_event(setup_event(8'h81, REQ_FETCH_DESC, {DTYPE_HID_REPORT, 8'h00}, 16'hFF00,
                             16'hFFFF));
      send_event(setup_event(8'h81, REQ_FETCH_DESC, {DTYPE_HID_REPORT, 8'h00}, 16'h0001,
                             16'h0000));
      send_event(setup_event(8'h80, REQ_FETCH_DESC, 16'hFFFF, 16'h0000, 16'hFFFF));
   endtask

   task automatic test_packet_size_extremes();
      drain_responses();
      write_register(CSR_MAX_PACKET, 32'd127);
      send_event(setup_event(8'h81, REQ_FETCH_DESC, {DTYPE_HID_REPORT, 8'h00}, 16'h0005,
                             16'hFFFF));
      send_event(plain_event(MODE_READY, 7'd0));
      send_event(plain_event(MODE_READY, 7'd0));
      drain_responses();
      // With a zero packet size the transfer never advances.
      write_register(CSR_MAX_PACKET, 32'd0);
      write_register(CSR_DEVICE_LEN, 32'd255);
      send_event(setup_event(8'h80, REQ_FETCH_DESC, {DTYPE_DEVICE, 8'h00}, 16'h0000,
                             16'hFFFF));
      send_event(plain_event(MODE_READY, 7'd0));
      send_event(plain_event(MODE_READY, 7'd0));
      drain_responses();
      write_register(CSR_MAX_PACKET, 32'd64);
   endtask

   task automatic run_descriptor_transfer();
      ep0_event_type e;
      logic [7:0] dtype;
      logic [7:0] sub;
      int cap;
      int n;
      case ($urandom_range(0, 6))
         0: dtype = DTYPE_DEVICE;
         1: dtype = DTYPE_CONFIG;
         2, 3: dtype = DTYPE_STRING;
         4: dtype = DTYPE_QUALIFIER;
         5: dtype = DTYPE_HID_REPORT;
         default: dtype = 8'($urandom);
      endcase
      sub = 8'($urandom);
      if ($urandom_range(0, 7) != 0) sub = 8'($urandom_range(0, 4));
      e = setup_event(8'h80, REQ_FETCH_DESC, {dtype, sub}, 16'h0000, 16'h0000);
      e.rtype = 8'($urandom);
      if ($urandom_range(0, 9) != 0) e.rtype[6:5] = REQ_TYPE_STANDARD;
      e.index = 16'($urandom);
      if ($urandom_range(0, 1) == 0) e.index[7:0] = 8'h00;
      case ($urandom_range(0, 9))
         0: e.length = 16'hFFFF;
         1: e.length = 16'($urandom);
         default: e.length = 16'($urandom_range(0, 200));
      endcase
      send_event(e);
      cap = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2) : READY_CAP;
      n = 0;
      while (ctl_in_data && n < cap) begin
         send_event(plain_event(MODE_READY, 7'd0));
         n++;
      end
      if ($urandom_range(0, 3) == 0) send_event(plain_event(MODE_READY, 7'd0));
      if ($urandom_range(0, 4) != 0) send_event(plain_event(MODE_PACKET, RX_LEN_STATUS));
   endtask

   task automatic run_address_sequence();
      ep0_event_type e;
      e = setup_event(8'h00, REQ_ASSIGN_ADDR, 16'h0000, 16'h0000, 16'h0000);
      e.rtype = 8'($urandom);
      if ($urandom_range(0, 7) != 0) e.rtype[6:5] = REQ_TYPE_STANDARD;
      e.value = 16'($urandom);
      e.index = 16'($urandom);
      e.length = 16'($urandom);
      send_event(e);
      if ($urandom_range(0, 3) == 0) send_event(plain_event(MODE_READY, 7'd0));
      send_event(plain_event(MODE_PACKET, RX_LEN_STATUS));
      if ($urandom_range(0, 4) == 0) send_event(plain_event(MODE_BUS_RESET, 7'd0));
   endtask

   task automatic send_noise_event();
      ep0_event_type e;
      logic [95:0]   raw;
      raw = {$urandom, $urandom, $urandom};
      e = raw[72:0];
      case ($urandom_range(0, 3))
         0: e.rx_length = RX_LEN_STATUS;
         1: e.rx_length = RX_LEN_SETUP;
         default: ;
      endcase
      send_event(e);
   endtask

   task automatic test_random_traffic();
      int target;
      for (int phase = 0; phase < 6; phase++) begin
         drain_responses();
         case (phase)
            0: load_config(7'd8, 8'd0, 16'd0, 32'd0, 8'd0, 16'd0, 16'd0);
            1: load_config(7'd64, 8'hFF, 16'hFFFF, 32'hFFFFFFFF, 8'hFF, 16'hFFFF, 16'hFFFF);
            2: load_config(7'd127, 8'($urandom), 16'($urandom_range(0, 300)), $urandom,
                           8'($urandom), 16'($urandom_range(0, 300)),
                           16'($urandom_range(0, 300)));
            default: load_config(7'($urandom_range(8, 64)), 8'($urandom),
                                 16'($urandom_range(0, 300)), $urandom, 8'($urandom),
                                 16'($urandom_range(0, 300)),
                                 16'($urandom_range(0, 300)));
         endcase
         target = sent_items + PHASE_ITEMS;
         while (sent_items < target) begin
            if (phase == 5) idle_on = 1'b0;
            else if ($urandom_range(0, 19) == 0) idle_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5: run_descriptor_transfer();
               6: run_address_sequence();
               default: send_noise_event();
            endcase
         end
      end
   endtask

   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall = 1'b1;
         stall_left = stall_left - 1;
      end else begin
         rsp_stall = 1'b0;
         if (idle_on && $urandom_range(0, 6) == 0) stall_left = $urandom_range(1, 13);
      end
   end

   always @(posedge clock) begin : check_responses
      ep0_response_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (pending_responses.size() == 0) begin
            report_mismatch("response arrived with nothing expected");
         end else begin
            want = pending_responses.pop_front();
            compare_field("send_packet", 16'(rsp_send_packet), 16'(want.send));
            compare_field("descriptor_select", 16'(rsp_descriptor_select),
                          16'(want.select));
            compare_field("byte_offset", rsp_byte_offset, want.offset);
            compare_field("packet_length", 16'(rsp_packet_length), 16'(want.length));
            compare_field("last_packet", 16'(rsp_last_packet), 16'(want.last));
            compare_field("device_address", 16'(rsp_device_address), 16'(want.address));
            compare_field("status_done", 16'(rsp_status_done), 16'(want.status));
         end
         checked_count++;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no handshake for %0d cycles, %0d responses outstanding",
                  quiet_cycles, pending_responses.size());
         $display("[usb_ep0_descriptor_responder] ERROR");
         $finish;
      end
   end

   initial begin
      reset_model();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_reset_defaults();
      test_address_and_status();
      test_descriptor_select();
      test_packet_size_extremes();
      test_random_traffic();
      drain_responses();
      repeat (4) @(posedge clock);
      if (error_count == 0)
         $display("[usb_ep0_descriptor_responder] OK");
      else
         $display("[usb_ep0_descriptor_responder] ERROR");
      $finish;
   end

endmodule
